// ----- rtl/mvts_pkg.sv -----
// Shared types and constants of the multi-voice tone sequencer.
`default_nettype none

package mvts_pkg;

    // Item opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Configuration register indexes
    localparam logic CFG_SLOT_LENGTH = 1'b0;
    localparam logic CFG_SLOT_COUNT  = 1'b1;

    localparam int CFG_DATA_W  = 16;
    localparam int SLOT_FIELD_W = 7;
    localparam int STEP_W       = 23;
    localparam int AMP_W        = 15;
    localparam int SAMPLE_W     = 16;
    localparam int ROM_DATA_W   = 16;

    localparam logic [15:0] SLOT_LENGTH_RESET = 16'd9000;
    localparam logic [7:0]  SLOT_COUNT_RESET  = 8'd128;

    localparam real TWO_PI = 6.283185307179586;

    // One stored note; the used flag lives apart in flip-flops
    typedef struct packed {
        logic [SLOT_FIELD_W-1:0] begin_slot;
        logic [SLOT_FIELD_W-1:0] end_slot;
        logic [STEP_W-1:0]       phase_step;
        logic [AMP_W-1:0]        amplitude;
    } note_entry_t;

endpackage

`default_nettype wire

// ----- rtl/multi_voice_tone_sequencer_unit.sv -----
// Top level: slot sequencing, note scan and the shared per-voice synthesis unit.
// A tick's sample is computed by the serial per-voice pass through the shared phase/multiply
// unit, preceded by the serial note scan on the first tick of a slot.
// The input is stalled while a tick is in progress, so no new item is taken before the last
// tick's sample is done; a stalled output holds the input off.
// Reset clears all note used flags, phases, steps, amplitudes and slot counters,
// and loads 9000 ticks per slot and 128 slots.
`default_nettype none

module multi_voice_tone_sequencer_unit #(
    parameter int VOICES            = 3,
    parameter int ENTRIES_PER_VOICE = 64,
    parameter int MAX_SLOTS         = 128,
    parameter int PHASE_BITS        = 24,
    parameter int SINE_TABLE_DEPTH  = 1024
) (
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               cfg_write,
    input  wire logic               cfg_index,
    input  wire logic [mvts_pkg::CFG_DATA_W-1:0] cfg_data,

    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               opcode,
    input  wire logic [1:0]         voice,
    input  wire logic [5:0]         entry_index,
    input  wire logic               entry_valid,
    input  wire logic [6:0]         begin_slot,
    input  wire logic [6:0]         end_slot,
    input  wire logic [22:0]        phase_step,
    input  wire logic [14:0]        amplitude,

    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [15:0]      sample,
    output logic [6:0]              slot_number
);

    localparam int MEM_DEPTH  = VOICES * ENTRIES_PER_VOICE;
    localparam int MEM_AW     = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int VIDX_W     = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int EIDX_W     = (ENTRIES_PER_VOICE > 1) ? $clog2(ENTRIES_PER_VOICE) : 1;
    localparam int SLOT_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int ROM_AW     = $clog2(SINE_TABLE_DEPTH);
    localparam int IDX_PROD_W = PHASE_BITS + ROM_AW;
    localparam int ACC_W      = mvts_pkg::SAMPLE_W + $clog2(VOICES) + 1;
    localparam int PROD_W     = mvts_pkg::ROM_DATA_W + mvts_pkg::AMP_W + 1;

    localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(-32768);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_PHASE,
        S_INDEX,
        S_ROM,
        S_MUL,
        S_ACC
    } state_t;

    state_t state_reg;
    logic   done_reg;

    // Configuration and slot position
    logic [15:0]       slot_length_reg;
    logic [7:0]        slot_count_reg;
    logic [15:0]       tick_reg;
    logic [SLOT_W-1:0] slot_reg;

    // Per-voice state
    logic [PHASE_BITS-1:0]          phase_reg [VOICES];
    logic [PHASE_BITS-1:0]          step_reg  [VOICES];
    logic [mvts_pkg::AMP_W-1:0]     amp_reg   [VOICES];
    logic [VOICES-1:0]              found_reg;

    // Scan and shared-unit registers
    logic [VIDX_W-1:0]              vcnt_reg;
    logic [EIDX_W-1:0]              ecnt_reg;
    logic [MEM_AW-1:0]              scan_addr_reg;
    logic                           rd_pend_reg;
    logic [VIDX_W-1:0]              rd_voice_reg;
    logic [ROM_AW-1:0]              rom_addr_reg;
    logic signed [PROD_W-1:0]       prod_reg;
    logic signed [ACC_W-1:0]        acc_reg;

    // Output register
    logic                           out_valid_reg;
    logic signed [15:0]             sample_reg;
    logic [6:0]                     slot_number_reg;

    // Memory and ROM connections
    logic                           wr_en;
    logic [MEM_AW-1:0]              wr_addr;
    mvts_pkg::note_entry_t          wr_entry;
    logic                           rd_valid;
    mvts_pkg::note_entry_t          rd_entry;
    logic signed [mvts_pkg::ROM_DATA_W-1:0] rom_data;

    logic                           in_xfer;
    logic                           scan_last;
    logic                           voice_last;
    logic                           note_hit;
    logic [PHASE_BITS-1:0]          phase_sum;
    logic [IDX_PROD_W-1:0]          idx_prod;
    logic signed [ACC_W-1:0]        acc_sum;
    logic signed [15:0]             sat_sample;
    logic [15:0]                    len_eff;
    logic [16:0]                    tick_inc;
    logic [8:0]                     cnt_eff;
    logic [8:0]                     slot_inc;
    logic [15:0]                    tick_next;
    logic [SLOT_W-1:0]              slot_next;
    logic                           out_free;

    assign in_stall = (state_reg != S_IDLE) || done_reg;
    assign in_xfer  = in_valid && !in_stall;

    assign wr_en = in_xfer && (opcode == mvts_pkg::OP_WRITE)
                   && (32'(voice) < VOICES) && (32'(entry_index) < ENTRIES_PER_VOICE);
    assign wr_addr = MEM_AW'(32'(voice) * ENTRIES_PER_VOICE + 32'(entry_index));
    assign wr_entry = '{begin_slot: begin_slot, end_slot: end_slot,
                        phase_step: phase_step, amplitude: amplitude};

    mvts_note_mem #(
        .DEPTH  (MEM_DEPTH),
        .ADDR_W (MEM_AW)
    ) u_note_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_valid (entry_valid),
        .wr_entry (wr_entry),
        .rd_addr  (scan_addr_reg),
        .rd_valid (rd_valid),
        .rd_entry (rd_entry)
    );

    mvts_sine_rom #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .ADDR_W           (ROM_AW)
    ) u_sine_rom (
        .clk  (clk),
        .addr (rom_addr_reg),
        .data (rom_data)
    );

    assign scan_last  = (vcnt_reg == VIDX_W'(VOICES - 1))
                        && (ecnt_reg == EIDX_W'(ENTRIES_PER_VOICE - 1));
    assign voice_last = (vcnt_reg == VIDX_W'(VOICES - 1));

    // First matching used entry of a voice wins
    assign note_hit = rd_pend_reg && rd_valid && !found_reg[rd_voice_reg]
                      && (8'(rd_entry.begin_slot) <= 8'(slot_reg))
                      && (8'(slot_reg) <= 8'(rd_entry.end_slot));

    assign phase_sum = phase_reg[vcnt_reg] + step_reg[vcnt_reg];
    assign idx_prod  = IDX_PROD_W'(phase_reg[vcnt_reg]) * IDX_PROD_W'(SINE_TABLE_DEPTH);
    assign acc_sum   = acc_reg + ACC_W'(prod_reg >>> 15);

    always_comb
    begin
        if (acc_reg > ACC_MAX)
        begin
            sat_sample = 16'sh7FFF;
        end
        else if (acc_reg < ACC_MIN)
        begin
            sat_sample = 16'sh8000;
        end
        else
        begin
            sat_sample = 16'(acc_reg);
        end
    end

    // Slot position after this tick
    assign len_eff  = (slot_length_reg == 16'd0) ? 16'd1 : slot_length_reg;
    assign tick_inc = {1'b0, tick_reg} + 17'd1;
    assign slot_inc = 9'(slot_reg) + 9'd1;

    always_comb
    begin
        if (slot_count_reg == 8'd0)
        begin
            cnt_eff = 9'd1;
        end
        else if ({1'b0, slot_count_reg} > 9'(MAX_SLOTS))
        begin
            cnt_eff = 9'(MAX_SLOTS);
        end
        else
        begin
            cnt_eff = {1'b0, slot_count_reg};
        end

        if (tick_inc >= {1'b0, len_eff})
        begin
            tick_next = 16'd0;
            slot_next = (slot_inc >= cnt_eff) ? '0 : SLOT_W'(slot_inc);
        end
        else
        begin
            tick_next = tick_inc[15:0];
            slot_next = slot_reg;
        end
    end

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            done_reg        <= 1'b0;
            slot_length_reg <= mvts_pkg::SLOT_LENGTH_RESET;
            slot_count_reg  <= mvts_pkg::SLOT_COUNT_RESET;
            tick_reg        <= '0;
            slot_reg        <= '0;
            for (int v = 0; v < VOICES; v++)
            begin
                phase_reg[v] <= '0;
                step_reg[v]  <= '0;
                amp_reg[v]   <= '0;
            end
            found_reg       <= '0;
            vcnt_reg        <= '0;
            ecnt_reg        <= '0;
            scan_addr_reg   <= '0;
            rd_pend_reg     <= 1'b0;
            rd_voice_reg    <= '0;
            rom_addr_reg    <= '0;
            prod_reg        <= '0;
            acc_reg         <= '0;
            out_valid_reg   <= 1'b0;
            sample_reg      <= '0;
            slot_number_reg <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    mvts_pkg::CFG_SLOT_LENGTH: slot_length_reg <= cfg_data;
                    mvts_pkg::CFG_SLOT_COUNT:  slot_count_reg  <= cfg_data[7:0];
                    default: ;
                endcase
            end

            // Load a finished sample, else drop the one taken downstream
            if ((state_reg == S_IDLE) && done_reg && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            rd_pend_reg  <= (state_reg == S_SCAN);
            rd_voice_reg <= vcnt_reg;

            case (state_reg)
                S_IDLE:
                begin
                    if (done_reg)
                    begin
                        // Hold the finished sample until the output register frees up
                        if (out_free)
                        begin
                            sample_reg      <= sat_sample;
                            slot_number_reg <= 7'(slot_reg);
                            tick_reg        <= tick_next;
                            slot_reg        <= slot_next;
                            done_reg        <= 1'b0;
                        end
                    end
                    else if (in_xfer && (opcode == mvts_pkg::OP_TICK))
                    begin
                        vcnt_reg <= '0;
                        acc_reg  <= '0;
                        if (tick_reg == 16'd0)
                        begin
                            for (int v = 0; v < VOICES; v++)
                            begin
                                step_reg[v] <= '0;
                                amp_reg[v]  <= '0;
                            end
                            found_reg     <= '0;
                            ecnt_reg      <= '0;
                            scan_addr_reg <= '0;
                            state_reg     <= S_SCAN;
                        end
                        else
                        begin
                            state_reg <= S_PHASE;
                        end
                    end
                end

                S_SCAN:
                begin
                    scan_addr_reg <= scan_addr_reg + MEM_AW'(1);
                    if (ecnt_reg == EIDX_W'(ENTRIES_PER_VOICE - 1))
                    begin
                        ecnt_reg <= '0;
                        vcnt_reg <= vcnt_reg + VIDX_W'(1);
                    end
                    else
                    begin
                        ecnt_reg <= ecnt_reg + EIDX_W'(1);
                    end
                    if (scan_last)
                    begin
                        state_reg <= S_DRAIN;
                    end
                end

                S_DRAIN:
                begin
                    // Last read is judged this cycle
                    vcnt_reg  <= '0;
                    state_reg <= S_PHASE;
                end

                S_PHASE:
                begin
                    phase_reg[vcnt_reg] <= phase_sum;
                    state_reg           <= S_INDEX;
                end

                S_INDEX:
                begin
                    rom_addr_reg <= idx_prod[IDX_PROD_W-1:PHASE_BITS];
                    state_reg    <= S_ROM;
                end

                S_ROM:
                begin
                    state_reg <= S_MUL;
                end

                S_MUL:
                begin
                    prod_reg  <= PROD_W'(rom_data * $signed({1'b0, amp_reg[vcnt_reg]}));
                    state_reg <= S_ACC;
                end

                S_ACC:
                begin
                    acc_reg <= acc_sum;
                    if (voice_last)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        vcnt_reg  <= vcnt_reg + VIDX_W'(1);
                        state_reg <= S_PHASE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            // Load the chosen note of a voice from the registered memory read
            if (note_hit)
            begin
                step_reg[rd_voice_reg]  <= PHASE_BITS'(rd_entry.phase_step);
                amp_reg[rd_voice_reg]   <= rd_entry.amplitude;
                found_reg[rd_voice_reg] <= 1'b1;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign sample      = sample_reg;
    assign slot_number = slot_number_reg;

endmodule

`default_nettype wire

// ----- rtl/mvts_note_mem.sv -----
// Note entry memory with per-entry used flags and a registered read port.
`default_nettype none

module mvts_note_mem #(
    parameter int DEPTH  = 192,
    parameter int ADDR_W = 8
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 wr_en,
    input  wire logic [ADDR_W-1:0]    wr_addr,
    input  wire logic                 wr_valid,
    input  wire mvts_pkg::note_entry_t wr_entry,
    input  wire logic [ADDR_W-1:0]    rd_addr,
    output logic                      rd_valid,
    output mvts_pkg::note_entry_t     rd_entry
);

    mvts_pkg::note_entry_t mem [DEPTH];
    logic [DEPTH-1:0]      valid_reg;
    logic                  rd_valid_reg;
    mvts_pkg::note_entry_t rd_entry_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
        rd_entry_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= wr_valid;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_valid = rd_valid_reg;
    assign rd_entry = rd_entry_reg;

endmodule

`default_nettype wire

// ----- rtl/mvts_sine_rom.sv -----
// Sine lookup ROM, Q1.15, one registered read per cycle.
`default_nettype none

module mvts_sine_rom #(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int ADDR_W           = 10
) (
    input  wire logic                                  clk,
    input  wire logic [ADDR_W-1:0]                     addr,
    output logic signed [mvts_pkg::ROM_DATA_W-1:0]     data
);

    typedef logic signed [mvts_pkg::ROM_DATA_W-1:0] rom_t [SINE_TABLE_DEPTH];

    // round(32767*sin(2*pi*k/depth)), ties away from zero; the exact
    // half values at 30 and 150 degrees (and their negatives) are pinned.
    function automatic rom_t build_rom();
        rom_t r;
        int   k;
        int   j;
        int   v;
        real  x;
        for (k = 0; k < SINE_TABLE_DEPTH; k++)
        begin
            x = mvts_pkg::TWO_PI * real'(k) / SINE_TABLE_DEPTH;
            v = int'(32767.0 * $sin(x));
            if (((k * 12) % SINE_TABLE_DEPTH) == 0)
            begin
                j = (k * 12) / SINE_TABLE_DEPTH;
                if (j == 1 || j == 5)
                begin
                    v = 16384;
                end
                else if (j == 7 || j == 11)
                begin
                    v = -16384;
                end
            end
            r[k] = mvts_pkg::ROM_DATA_W'(v);
        end
        return r;
    endfunction

    localparam rom_t ROM = build_rom();

    logic signed [mvts_pkg::ROM_DATA_W-1:0] data_reg;

    always_ff @(posedge clk)
    begin
        data_reg <= ROM[addr];
    end

    assign data = data_reg;

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the multi-voice tone sequencer: directed table, then random phases.
`timescale 1ns / 1ps

module testbench;

    localparam int NUM_VOICES    = 3;
    localparam int NUM_ENTRIES   = 64;
    localparam int TOP_SLOTS     = 128;
    localparam int WAVE_DEPTH    = 1024;
    localparam real PI_VAL       = 3.14159265358979323846;
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 112;
    localparam int SETTLE_CYCLES = 250;
    localparam int CYCLE_LIMIT   = 2000000;

    typedef struct packed {
        logic signed [mvts_pkg::SAMPLE_W-1:0] smp;
        logic [6:0]                           slot;
    } tone_out_t;

    typedef struct packed {
        logic       op;
        logic [1:0] vc;
        logic [5:0] idx;
        logic       ev;
        logic [6:0] first;
        logic [6:0] last;
        logic [22:0] inc;
        logic [14:0] amp;
        logic       typed;
        tone_out_t  want;
    } stim_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_write;
    logic cfg_index;
    logic [15:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic opcode;
    logic [1:0] voice;
    logic [5:0] entry_index;
    logic entry_valid;
    logic [6:0] begin_slot;
    logic [6:0] end_slot;
    logic [22:0] phase_step;
    logic [14:0] amplitude;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [15:0] sample;
    logic [6:0] slot_number;

    // Predictor state
    int                    sine_q15 [WAVE_DEPTH];
    mvts_pkg::note_entry_t note_mem [NUM_VOICES][NUM_ENTRIES];
    bit                    note_used [NUM_VOICES][NUM_ENTRIES];
    logic [23:0]           phase_acc [NUM_VOICES];
    logic [22:0]           live_step [NUM_VOICES];
    logic [14:0]           live_amp [NUM_VOICES];
    int                    tick_pos;
    int                    cur_slot;
    logic [15:0]           slot_len;
    logic [7:0]            slot_cnt;

    tone_out_t pending_samples[$];
    stim_t     directed[$];

    int gap_pct = 13;
    int stall_pct = 50;
    int mismatches = 0;
    int samples_seen = 0;
    int notes_written = 0;
    int settings_used = 0;
    int cycle_count = 0;

    multi_voice_tone_sequencer_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .opcode(opcode),
        .voice(voice),
        .entry_index(entry_index),
        .entry_valid(entry_valid),
        .begin_slot(begin_slot),
        .end_slot(end_slot),
        .phase_step(phase_step),
        .amplitude(amplitude),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .sample(sample),
        .slot_number(slot_number)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void build_sine();
        int  k;
        real s;
        for (k = 0; k < WAVE_DEPTH; k++)
        begin
            s = 32767.0 * $sin(2.0 * PI_VAL * k / WAVE_DEPTH);
            // round half away from zero
            if (s >= 0.0)
                sine_q15[k] = $rtoi(s + 0.5);
            else
                sine_q15[k] = -$rtoi(0.5 - s);
        end
    endfunction

    function automatic void clear_state();
        int v;
        int e;
        for (v = 0; v < NUM_VOICES; v++)
        begin
            for (e = 0; e < NUM_ENTRIES; e++)
            begin
                note_used[v][e] = 1'b0;
                note_mem[v][e] = '0;
            end
            phase_acc[v] = '0;
            live_step[v] = '0;
            live_amp[v] = '0;
        end
        tick_pos = 0;
        cur_slot = 0;
        slot_len = mvts_pkg::SLOT_LENGTH_RESET;
        slot_cnt = mvts_pkg::SLOT_COUNT_RESET;
    endfunction

    function automatic void store_note(input stim_t it);
        if (it.vc < NUM_VOICES)
        begin
            note_used[it.vc][it.idx] = it.ev;
            note_mem[it.vc][it.idx].begin_slot = it.first;
            note_mem[it.vc][it.idx].end_slot = it.last;
            note_mem[it.vc][it.idx].phase_step = it.inc;
            note_mem[it.vc][it.idx].amplitude = it.amp;
        end
    endfunction

    function automatic void select_notes();
        int v;
        int e;
        for (v = 0; v < NUM_VOICES; v++)
        begin
            live_step[v] = '0;
            live_amp[v] = '0;
            // scan downward so the lowest matching entry is the one kept
            for (e = NUM_ENTRIES - 1; e >= 0; e--)
            begin
                if (note_used[v][e] && note_mem[v][e].begin_slot <= cur_slot &&
                    cur_slot <= note_mem[v][e].end_slot)
                begin
                    live_step[v] = note_mem[v][e].phase_step;
                    live_amp[v] = note_mem[v][e].amplitude;
                end
            end
        end
    endfunction

    function automatic tone_out_t synth_tick();
        tone_out_t res;
        int v;
        int acc;
        int prod;
        int len;
        int cnt;
        acc = 0;
        if (tick_pos == 0)
            select_notes();
        for (v = 0; v < NUM_VOICES; v++)
        begin
            phase_acc[v] = phase_acc[v] + {1'b0, live_step[v]};
            prod = sine_q15[phase_acc[v][23:14]] * int'(live_amp[v]);
            acc += prod >>> 15;
        end
        if (acc > 32767)
            acc = 32767;
        else if (acc < -32768)
            acc = -32768;
        res.smp = acc[15:0];
        res.slot = cur_slot[6:0];

        len = (slot_len == 0) ? 1 : int'(slot_len);
        cnt = (slot_cnt == 0) ? 1 : ((slot_cnt > TOP_SLOTS) ? TOP_SLOTS : int'(slot_cnt));
        tick_pos++;
        if (tick_pos >= len)
        begin
            tick_pos = 0;
            cur_slot++;
            if (cur_slot >= cnt)
                cur_slot = 0;
        end
        return res;
    endfunction

    function automatic stim_t note_row(input logic [1:0] vc, input logic [5:0] idx,
                                       input logic ev, input logic [6:0] first,
                                       input logic [6:0] last, input logic [22:0] inc,
                                       input logic [14:0] amp);
        stim_t it;
        it = '0;
        it.op = mvts_pkg::OP_WRITE;
        it.vc = vc;
        it.idx = idx;
        it.ev = ev;
        it.first = first;
        it.last = last;
        it.inc = inc;
        it.amp = amp;
        return it;
    endfunction

    function automatic stim_t tick_row(input logic typed, input logic signed [15:0] smp,
                                       input logic [6:0] slot);
        stim_t it;
        it = '0;
        it.op = mvts_pkg::OP_TICK;
        it.typed = typed;
        it.want.smp = smp;
        it.want.slot = slot;
        return it;
    endfunction

    function automatic stim_t random_item();
        stim_t it;
        int span;
        it = '0;
        span = (slot_cnt == 0) ? 1 : ((slot_cnt > TOP_SLOTS) ? TOP_SLOTS : int'(slot_cnt));
        // ticks carry random noise in the unused fields
        it.vc = 2'($urandom);
        it.idx = 6'($urandom);
        it.ev = 1'($urandom);
        it.first = 7'($urandom);
        it.last = 7'($urandom);
        it.inc = 23'($urandom);
        it.amp = 15'($urandom);
        if ($urandom_range(99) < 30)
        begin
            it.op = mvts_pkg::OP_WRITE;
            it.vc = ($urandom_range(99) < 6) ? 2'd3 : 2'($urandom_range(2));
            if ($urandom_range(99) < 70)
                it.idx = 6'($urandom_range(7));
            it.ev = ($urandom_range(99) < 85);
            if ($urandom_range(99) < 80)
            begin
                it.first = 7'($urandom_range(span - 1));
                it.last = 7'($urandom_range(span - 1, int'(it.first)));
            end
            if ($urandom_range(99) < 20)
                it.inc = 23'($urandom_range(4095));
            if ($urandom_range(99) < 15)
                it.amp = 15'h7FFF;
        end
        else
        begin
            it.op = mvts_pkg::OP_TICK;
        end
        return it;
    endfunction

    task automatic set_slots(input logic [15:0] len, input logic [15:0] cnt);
        cfg_write <= 1'b1;
        cfg_index <= mvts_pkg::CFG_SLOT_LENGTH;
        cfg_data <= len;
        @(negedge clk);
        cfg_index <= mvts_pkg::CFG_SLOT_COUNT;
        cfg_data <= cnt;
        @(negedge clk);
        cfg_write <= 1'b0;
        slot_len = len;
        slot_cnt = cnt[7:0];
        settings_used++;
    endtask

    // Hold the input off until every sample is back and the block has gone quiet
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_samples.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic send(input stim_t it);
        tone_out_t res;
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        opcode <= it.op;
        voice <= it.vc;
        entry_index <= it.idx;
        entry_valid <= it.ev;
        begin_slot <= it.first;
        end_slot <= it.last;
        phase_step <= it.inc;
        amplitude <= it.amp;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // transfer taken at this edge
        if (it.op == mvts_pkg::OP_TICK)
        begin
            res = synth_tick();
            if (it.typed)
                pending_samples.push_back(it.want);
            else
                pending_samples.push_back(res);
        end
        else
        begin
            store_note(it);
            if (it.vc < NUM_VOICES)
                notes_written++;
        end
        @(negedge clk);
    endtask

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin : check_samples
        tone_out_t want;
        if (out_valid === 1'b1 && out_stall === 1'b0)
        begin
            samples_seen++;
            if (pending_samples.size() == 0)
            begin
                mismatches++;
                $display("%0t: sample with none pending, expected nothing, actual %0d slot %0d",
                         $time, sample, slot_number);
            end
            else
            begin
                want = pending_samples.pop_front();
                if (sample !== want.smp)
                begin
                    mismatches++;
                    $display("%0t: sample expected %0d, actual %0d",
                             $time, $signed(want.smp), sample);
                end
                if (slot_number !== want.slot)
                begin
                    mismatches++;
                    $display("%0t: slot_number expected %0d, actual %0d",
                             $time, want.slot, slot_number);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d samples pending", $time, pending_samples.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        stim_t it;
        int p;
        int counted;
        logic [15:0] cnt_word;

        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = mvts_pkg::CFG_SLOT_LENGTH;
        cfg_data = '0;
        in_valid = 1'b0;
        opcode = mvts_pkg::OP_WRITE;
        voice = '0;
        entry_index = '0;
        entry_valid = 1'b0;
        begin_slot = '0;
        end_slot = '0;
        phase_step = '0;
        amplitude = '0;
        build_sine();
        clear_state();

        // One-tick slots, four slots: every tick starts a slot
        directed.push_back(tick_row(1'b1, 16'sd0, 7'd0));
        directed.push_back(note_row(2'd0, 6'd0, 1'b1, 7'd0, 7'd127, 23'h400000, 15'h7FFF));
        directed.push_back(note_row(2'd1, 6'd0, 1'b1, 7'd0, 7'd127, 23'h400000, 15'h7FFF));
        directed.push_back(note_row(2'd2, 6'd0, 1'b1, 7'd0, 7'd127, 23'h400000, 15'h7FFF));
        directed.push_back(tick_row(1'b1, 16'sd32767, 7'd1));
        directed.push_back(tick_row(1'b1, 16'sd0, 7'd2));
        directed.push_back(tick_row(1'b1, 16'sh8000, 7'd3));
        directed.push_back(tick_row(1'b1, 16'sd0, 7'd0));
        // nonexistent voice, then a shadowed entry uncovered by clearing entry zero
        directed.push_back(note_row(2'd3, 6'd63, 1'b1, 7'd0, 7'd127, 23'h7FFFFF, 15'h7FFF));
        directed.push_back(note_row(2'd0, 6'd63, 1'b1, 7'd0, 7'd127, 23'h7FFFFF, 15'h5555));
        directed.push_back(note_row(2'd0, 6'd0, 1'b0, 7'd127, 7'd0, 23'h000000, 15'h0000));
        // begin after end never matches, so voice one falls silent
        directed.push_back(note_row(2'd1, 6'd0, 1'b1, 7'd3, 7'd1, 23'h123456, 15'h2AAA));
        directed.push_back(note_row(2'd2, 6'd0, 1'b1, 7'd1, 7'd1, 23'h2AAAAA, 15'h7FFF));
        directed.push_back(note_row(2'd2, 6'd2, 1'b1, 7'd0, 7'd127, 23'h000001, 15'h0001));
        repeat (5) directed.push_back(tick_row(1'b0, 16'sd0, 7'd0));

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        set_slots(16'd1, 16'd4);
        foreach (directed[i])
            send(directed[i]);

        for (p = 0; p < PHASES; p++)
        begin
            if (p == 4)
            begin
                gap_pct = 50;
                stall_pct = 13;
            end
            if (p == 8)
            begin
                gap_pct = 0;
                stall_pct = 0;
            end
            drain();
            case (p)
                0: set_slots(16'd0, 16'd5);
                1: set_slots(16'd1, 16'd1);
                2: set_slots(16'hFFFF, 16'd128);
                3: set_slots(16'd2, 16'd0);
                4: set_slots(16'd3, 16'hFFFF);
                5: set_slots(16'd5, 16'd128);
                default:
                begin
                    cnt_word = 16'($urandom_range(12, 1));
                    cnt_word[15:8] = 8'($urandom_range(255));
                    set_slots(16'($urandom_range(6, 1)), cnt_word);
                end
            endcase
            counted = 0;
            while (counted < PHASE_ITEMS)
            begin
                it = random_item();
                send(it);
                if (!(it.op == mvts_pkg::OP_WRITE && it.vc >= NUM_VOICES))
                    counted++;
            end
        end

        drain();
        $display("Covered %0d note writes and %0d samples over %0d slot settings,",
                 notes_written, samples_seen, settings_used);
        $display("with sender gaps and receiver stalls taking turns, then none.");
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/mvts_pkg.sv
rtl/mvts_note_mem.sv
rtl/mvts_sine_rom.sv
rtl/multi_voice_tone_sequencer_unit.sv
tb/testbench.sv
